/* rtl/lfpd_pkg.sv */
// ============================================================================
// lfpd_pkg: shared types and constants of the line follower motor drive
// Field widths, kind codes, register indexes and the item and result
// structures that pass between the front end, the queue and the back end.
// ============================================================================
package lfpd_pkg;

    localparam int LINE_SENSORS = 3;
    localparam int SAMPLE_BITS  = 12;
    localparam int PWM_MAX      = 999;

    localparam int DRIVE_W   = 10;
    localparam int SPEED_W   = 10;
    localparam int GAIN_W    = 16;
    localparam int OFFSET_W  = 12;
    localparam int KIND_W    = 3;
    localparam int ERR_W     = SAMPLE_BITS + 1;
    localparam int BASE_W    = SPEED_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [DRIVE_W-1:0]     drive_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CONTROL    = 3'd0,
        KIND_MONITOR    = 3'd1,
        KIND_CALIBRATE  = 3'd2,
        KIND_ARM_RUN    = 3'd3,
        KIND_ARM_MARKER = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_DERIV_GAIN    = 3'd1,
        REG_TARGET_SPEED  = 3'd2,
        REG_RAMP_STEP     = 3'd3,
        REG_LIMIT_UP      = 3'd4,
        REG_LIMIT_DOWN    = 3'd5,
        REG_MARKER_LEVEL  = 3'd6,
        REG_THRESH_OFFSET = 3'd7
    } reg_idx_t;

    // Decoded operation; an unused kind code leaves all bits clear.
    typedef struct packed {
        logic control;
        logic monitor;
        logic calibrate;
        logic arm_run;
        logic arm_marker;
    } op_t;

    typedef struct packed {
        op_t                         op;
        sample_t                     marker;
        sample_t [LINE_SENSORS-1:0]  line;   // 0 left, 1 centre, 2 right
    } item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [SPEED_W-1:0]  target_speed;
        logic [SPEED_W-1:0]  ramp_step;
        logic [SPEED_W-1:0]  limit_up;
        logic [SPEED_W-1:0]  limit_down;
        sample_t             marker_level;
        logic [OFFSET_W-1:0] threshold_offset;
    } cfg_t;

    // Packed so that left_forward lands in the lowest bits.
    typedef struct packed {
        logic                    marker_seen;
        logic                    running;
        logic [LINE_SENSORS-1:0] line_mask;
        drive_t                  right_reverse;
        drive_t                  right_forward;
        drive_t                  left_reverse;
        drive_t                  left_forward;
    } result_t;

endpackage

/* rtl/lfpd_cfg.sv */
// ============================================================================
// lfpd_cfg: configuration register file
// Holds the eight control registers, written one at a time by index.
// ============================================================================
module lfpd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfpd_pkg::CFG_DAT_W-1:0] cfg_data,
    output lfpd_pkg::cfg_t                 cfg
);

    lfpd_pkg::cfg_t cfg_reg;
    lfpd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (lfpd_pkg::reg_idx_t'(cfg_index))
                lfpd_pkg::REG_PROP_GAIN:
                    cfg_next.prop_gain = cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_DERIV_GAIN:
                    cfg_next.deriv_gain = cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_TARGET_SPEED:
                    cfg_next.target_speed = cfg_data[lfpd_pkg::SPEED_W-1:0];
                lfpd_pkg::REG_RAMP_STEP:
                    cfg_next.ramp_step = cfg_data[lfpd_pkg::SPEED_W-1:0];
                lfpd_pkg::REG_LIMIT_UP:
                    cfg_next.limit_up = cfg_data[lfpd_pkg::SPEED_W-1:0];
                lfpd_pkg::REG_LIMIT_DOWN:
                    cfg_next.limit_down = cfg_data[lfpd_pkg::SPEED_W-1:0];
                lfpd_pkg::REG_MARKER_LEVEL:
                    cfg_next.marker_level = cfg_data[lfpd_pkg::SAMPLE_BITS-1:0];
                lfpd_pkg::REG_THRESH_OFFSET:
                    cfg_next.threshold_offset = cfg_data[lfpd_pkg::OFFSET_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain        <= lfpd_pkg::GAIN_W'(256);
            cfg_reg.deriv_gain       <= '0;
            cfg_reg.target_speed     <= lfpd_pkg::SPEED_W'(500);
            cfg_reg.ramp_step        <= lfpd_pkg::SPEED_W'(10);
            cfg_reg.limit_up         <= lfpd_pkg::SPEED_W'(500);
            cfg_reg.limit_down       <= lfpd_pkg::SPEED_W'(500);
            cfg_reg.marker_level     <= lfpd_pkg::SAMPLE_BITS'(2048);
            cfg_reg.threshold_offset <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/lfpd_front.sv */
// ============================================================================
// lfpd_front: input stage
// Accepts input transactions, decodes the kind into an operation and holds
// the classified item until the queue takes it.
// ============================================================================
module lfpd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lfpd_pkg::KIND_W-1:0]       in_kind,
    input  logic [lfpd_pkg::IN_DATA_W-1:0]    in_data,
    output logic                              push,
    input  logic                              push_ready,
    output lfpd_pkg::item_t                   item
);

    logic            vld_reg;
    logic            vld_next;
    lfpd_pkg::item_t item_reg;
    lfpd_pkg::item_t item_next;
    lfpd_pkg::op_t   op;
    logic            accept;

    always_comb
    begin
        op = '0;
        case (lfpd_pkg::kind_t'(in_kind))
            lfpd_pkg::KIND_CONTROL:    op.control    = 1'b1;
            lfpd_pkg::KIND_MONITOR:    op.monitor    = 1'b1;
            lfpd_pkg::KIND_CALIBRATE:  op.calibrate  = 1'b1;
            lfpd_pkg::KIND_ARM_RUN:    op.arm_run    = 1'b1;
            lfpd_pkg::KIND_ARM_MARKER: op.arm_marker = 1'b1;
            default:                   op = '0;
        endcase
    end

    assign in_ready = !vld_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign push     = vld_reg;
    assign item     = item_reg;

    always_comb
    begin
        item_next = item_reg;
        if (accept)
        begin
            item_next.op     = op;
            item_next.line   = in_data[lfpd_pkg::LINE_SENSORS*lfpd_pkg::SAMPLE_BITS-1:0];
            item_next.marker = in_data[(lfpd_pkg::LINE_SENSORS+1)*lfpd_pkg::SAMPLE_BITS-1 :
                                       lfpd_pkg::LINE_SENSORS*lfpd_pkg::SAMPLE_BITS];
        end
        if (accept)
            vld_next = 1'b1;
        else if (push_ready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

/* rtl/lfpd_fifo.sv */
// ============================================================================
// lfpd_fifo: two-entry item queue
// Decouples the input stage from the execution stage.
// ============================================================================
module lfpd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            push_ready,
    input  lfpd_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop,
    output lfpd_pkg::item_t pop_item
);

    lfpd_pkg::item_t [1:0] mem_reg;
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* rtl/lfpd_back.sv */
// ============================================================================
// lfpd_back: execution stage
// Unless the output stalls, applies one queued item per cycle to the controller
// state (PD law, speed ramp, line mask, calibration, arming); registers result.
// ============================================================================
module lfpd_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lfpd_pkg::cfg_t                 cfg,
    input  logic                           item_valid,
    output logic                           item_pop,
    input  lfpd_pkg::item_t                item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lfpd_pkg::result_t              result
);

    localparam int ACC_W  = 31;
    localparam int FRAC_W = 8;
    localparam int U_W    = ACC_W - FRAC_W;
    localparam int CORR_W = lfpd_pkg::SPEED_W + 1;
    localparam int SP_W   = lfpd_pkg::BASE_W + 2;
    localparam int MID_W  = lfpd_pkg::SAMPLE_BITS + 2;
    localparam int LS     = lfpd_pkg::LINE_SENSORS;

    // Controller state
    logic signed [lfpd_pkg::ERR_W-1:0]  last_error_reg, last_error_next;
    logic [lfpd_pkg::BASE_W-1:0]        base_speed_reg, base_speed_next;
    lfpd_pkg::drive_t [3:0]             drive_reg, drive_next;
    lfpd_pkg::sample_t [LS-1:0]         thr_reg, thr_next;
    lfpd_pkg::sample_t [LS-1:0]         max_reg, max_next;
    lfpd_pkg::sample_t [LS-1:0]         min_reg, min_next;
    logic [LS-1:0]                      mask_reg, mask_next;
    logic                               loop_on_reg, loop_on_next;
    logic                               await_reg, await_next;

    // Output register
    logic                               out_valid_reg, out_valid_next;
    lfpd_pkg::result_t                  result_reg, result_next;

    // PD datapath
    logic signed [lfpd_pkg::GAIN_W-1:0] kp;
    logic signed [lfpd_pkg::GAIN_W-1:0] kd;
    logic signed [lfpd_pkg::ERR_W-1:0]  err;
    logic signed [lfpd_pkg::ERR_W:0]    diff;
    logic signed [ACC_W-1:0]            acc;
    logic signed [U_W-1:0]              u_full;
    logic signed [U_W-1:0]              lim_hi;
    logic signed [U_W-1:0]              lim_lo;
    logic signed [U_W-1:0]              u_clamp;
    logic signed [CORR_W-1:0]           u_sat;
    logic [lfpd_pkg::BASE_W-1:0]        base_ramp;
    logic signed [SP_W-1:0]             lmotor_cmd;
    logic signed [SP_W-1:0]             rmotor_cmd;
    logic signed [lfpd_pkg::OFFSET_W-1:0] offset;
    logic [LS-1:0]                      mask_now;
    logic                               exec;
    logic                               marker_high;

    logic [lfpd_pkg::SAMPLE_BITS:0]     mid_sum [LS];
    logic signed [MID_W-1:0]            mid_thr [LS];
    lfpd_pkg::sample_t                  cal_max [LS];
    lfpd_pkg::sample_t                  cal_min [LS];

    // Sign-magnitude split of a motor speed: {reverse, forward}.
    function automatic logic [2*lfpd_pkg::DRIVE_W-1:0] drive_pair(
        input logic signed [SP_W-1:0] speed
    );
        logic [SP_W-1:0]            mag;
        logic [lfpd_pkg::DRIVE_W-1:0] sat;
        logic [lfpd_pkg::DRIVE_W-1:0] fwd;
        logic [lfpd_pkg::DRIVE_W-1:0] rev;
        mag = speed[SP_W-1] ? SP_W'(-speed) : SP_W'(speed);
        if (mag > SP_W'(lfpd_pkg::PWM_MAX))
            sat = lfpd_pkg::DRIVE_W'(lfpd_pkg::PWM_MAX);
        else
            sat = mag[lfpd_pkg::DRIVE_W-1:0];
        fwd = (!speed[SP_W-1] && (speed != '0)) ? sat : '0;
        rev = speed[SP_W-1] ? sat : '0;
        return {rev, fwd};
    endfunction

    assign exec     = item_valid && (!out_valid_reg || out_ready);
    assign item_pop = exec;
    assign out_valid = out_valid_reg;
    assign result   = result_reg;

    assign kp     = cfg.prop_gain;
    assign kd     = cfg.deriv_gain;
    assign offset = cfg.threshold_offset;
    assign marker_high = item.marker > cfg.marker_level;

    // PD correction; the arithmetic shift gives floor division by 256.
    always_comb
    begin
        err    = $signed({1'b0, item.line[2]}) - $signed({1'b0, item.line[0]});
        diff   = (lfpd_pkg::ERR_W+1)'(err) - (lfpd_pkg::ERR_W+1)'(last_error_reg);
        acc    = ACC_W'(kp) * ACC_W'(err) + ACC_W'(kd) * ACC_W'(diff);
        u_full = acc[ACC_W-1:FRAC_W];
        lim_hi = $signed({{(U_W-lfpd_pkg::SPEED_W){1'b0}}, cfg.limit_up});
        lim_lo = -$signed({{(U_W-lfpd_pkg::SPEED_W){1'b0}}, cfg.limit_down});
        if (u_full > lim_hi)
            u_clamp = lim_hi;
        else if (u_full < lim_lo)
            u_clamp = lim_lo;
        else
            u_clamp = u_full;
        u_sat = u_clamp[CORR_W-1:0];

        if (base_speed_reg < lfpd_pkg::BASE_W'(cfg.target_speed))
            base_ramp = base_speed_reg + lfpd_pkg::BASE_W'(cfg.ramp_step);
        else
            base_ramp = base_speed_reg;
        lmotor_cmd = $signed({2'b00, base_ramp}) + SP_W'(u_sat);
        rmotor_cmd = $signed({2'b00, base_ramp}) - SP_W'(u_sat);
    end

    // Line mask and calibration per sensor
    always_comb
    begin
        for (int i = 0; i < LS; i++)
        begin
            mask_now[LS-1-i] = item.line[i] > thr_reg[i];
            cal_max[i] = (item.line[i] > max_reg[i]) ? item.line[i] : max_reg[i];
            cal_min[i] = (item.line[i] < min_reg[i]) ? item.line[i] : min_reg[i];
            mid_sum[i] = {1'b0, cal_min[i]} + {1'b0, cal_max[i]};
            mid_thr[i] = $signed({2'b00, mid_sum[i][lfpd_pkg::SAMPLE_BITS:1]})
                         + MID_W'(offset);
        end
    end

    always_comb
    begin
        last_error_next = last_error_reg;
        base_speed_next = base_speed_reg;
        drive_next      = drive_reg;
        thr_next        = thr_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        mask_next       = mask_reg;
        loop_on_next    = loop_on_reg;
        await_next      = await_reg;

        if (exec)
        begin
            if (item.op.control)
            begin
                if (!loop_on_reg)
                begin
                    base_speed_next = '0;
                    drive_next      = '0;
                end
                else if (item.line[1] > thr_reg[1])
                begin
                    base_speed_next = base_ramp;
                    last_error_next = err;
                    {drive_next[1], drive_next[0]} = drive_pair(lmotor_cmd);
                    {drive_next[3], drive_next[2]} = drive_pair(rmotor_cmd);
                end
            end
            else if (item.op.monitor)
            begin
                mask_next = mask_now;
                if (mask_now == '1)
                    loop_on_next = 1'b0;
                if (await_reg && !marker_high)
                begin
                    loop_on_next = 1'b1;
                    await_next   = 1'b0;
                end
            end
            else if (item.op.calibrate)
            begin
                for (int i = 0; i < LS; i++)
                begin
                    max_next[i] = cal_max[i];
                    min_next[i] = cal_min[i];
                    if (mid_thr[i] < 0)
                        thr_next[i] = '0;
                    else if (mid_thr[i] > $signed(MID_W'({lfpd_pkg::SAMPLE_BITS{1'b1}})))
                        thr_next[i] = '1;
                    else
                        thr_next[i] = mid_thr[i][lfpd_pkg::SAMPLE_BITS-1:0];
                end
            end
            else if (item.op.arm_run)
            begin
                if (mask_reg == LS'(2))
                    loop_on_next = 1'b1;
            end
            else if (item.op.arm_marker)
            begin
                await_next = 1'b1;
            end
        end

        result_next = result_reg;
        if (exec)
        begin
            result_next.left_forward  = drive_next[0];
            result_next.left_reverse  = drive_next[1];
            result_next.right_forward = drive_next[2];
            result_next.right_reverse = drive_next[3];
            result_next.line_mask     = mask_next;
            result_next.running       = loop_on_next;
            result_next.marker_seen   = await_next && marker_high;
        end

        if (exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            base_speed_reg <= '0;
            drive_reg      <= '0;
            thr_reg        <= '0;
            max_reg        <= '0;
            min_reg        <= '1;
            mask_reg       <= '0;
            loop_on_reg    <= 1'b0;
            await_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_error_reg <= last_error_next;
            base_speed_reg <= base_speed_next;
            drive_reg      <= drive_next;
            thr_reg        <= thr_next;
            max_reg        <= max_next;
            min_reg        <= min_next;
            mask_reg       <= mask_next;
            loop_on_reg    <= loop_on_next;
            await_reg      <= await_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

/* rtl/line_follow_pd_motor_drive.sv */
// ============================================================================
// line_follow_pd_motor_drive: PD line follower with two-motor PWM drive
// Input stage, two-entry queue and execution stage around the controller.
// ============================================================================
// Usage:
//   Each slave-side transaction carries one item: a kind on s_axis_tuser and
//   four sensor samples on s_axis_tdata. Every item yields exactly one
//   master-side transaction with the four PWM compare values, the line mask,
//   the running flag and the marker-seen flag.
//   Control ticks run the PD law and speed ramp, monitor ticks update the
//   line mask and stop/start logic, calibrate samples learn the thresholds,
//   and the two arm kinds start the loop.
//   Registers are written through the cfg channel (index, data) while no
//   item is in flight: a duty of the user that the block does not enforce.
//   cfg_ready is always high. Throughput: one item per cycle while the
//   receiver takes results; the execution stage updates all state at once,
//   so consecutive items need no spacing.
//   When the receiver stalls, the result holds in the output register, the
//   queue fills, and s_axis_tready drops only once the input stage and both
//   queue entries are occupied.
//   Reset clears the controller state (minimum trackers to full scale) and
//   loads the register defaults; the block accepts items right after reset.
// ============================================================================
module line_follow_pd_motor_drive (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [11:0] left_sample, [23:12] centre_sample, [35:24] right_sample,
    // [47:36] marker_sample
    input  logic [lfpd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] kind
    input  logic [lfpd_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [9:0] left_forward, [19:10] left_reverse, [29:20] right_forward,
    // [39:30] right_reverse, [42:40] line_mask, [43] running,
    // [44] marker_seen, [47:45] zero
    output logic [lfpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfpd_pkg::CFG_DAT_W-1:0]    cfg_data
);

    lfpd_pkg::cfg_t    cfg;
    lfpd_pkg::item_t   front_item;
    lfpd_pkg::item_t   queue_item;
    lfpd_pkg::result_t result;
    logic              push;
    logic              push_ready;
    logic              queue_valid;
    logic              queue_pop;

    lfpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .push       (push),
        .push_ready (push_ready),
        .item       (front_item)
    );

    lfpd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop        (queue_pop),
        .pop_item   (queue_item)
    );

    lfpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (queue_valid),
        .item_pop   (queue_pop),
        .item       (queue_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result     (result)
    );

    assign m_axis_tdata = lfpd_pkg::OUT_DATA_W'(result);

endmodule

/* test/motor_drive_checker.sv */
// ============================================================================
// motor_drive_checker: result predictor and comparator for the motor drive
// Watches the register channel, the item stream and the result stream. For
// every accepted item it computes the drive values, line mask and flags the
// block must return, queues them and compares each returned result in order.
// ============================================================================
module motor_drive_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [lfpd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [lfpd_pkg::KIND_W-1:0]     s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [lfpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfpd_pkg::CFG_DAT_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);

    // Register copy.
    logic signed [lfpd_pkg::GAIN_W-1:0]   kp;
    logic signed [lfpd_pkg::GAIN_W-1:0]   kd;
    logic [lfpd_pkg::SPEED_W-1:0]         tgt_speed;
    logic [lfpd_pkg::SPEED_W-1:0]         ramp;
    logic [lfpd_pkg::SPEED_W-1:0]         clamp_hi;
    logic [lfpd_pkg::SPEED_W-1:0]         clamp_lo;
    lfpd_pkg::sample_t                    mark_lvl;
    logic signed [lfpd_pkg::OFFSET_W-1:0] thr_ofs;

    // Controller state copy.
    logic signed [lfpd_pkg::ERR_W-1:0]    prev_err;
    logic [lfpd_pkg::BASE_W-1:0]          base;
    lfpd_pkg::drive_t                     drv [4];
    lfpd_pkg::sample_t                    thr [lfpd_pkg::LINE_SENSORS];
    lfpd_pkg::sample_t                    hi_seen [lfpd_pkg::LINE_SENSORS];
    lfpd_pkg::sample_t                    lo_seen [lfpd_pkg::LINE_SENSORS];
    logic [lfpd_pkg::LINE_SENSORS-1:0]    mask;
    logic                                 loop_on;
    logic                                 await_mk;

    lfpd_pkg::result_t drive_results_due [$];

    function automatic void split_speed(input int spd, output lfpd_pkg::drive_t fwd,
                                        output lfpd_pkg::drive_t rev);
        int mag;
        mag = (spd < 0) ? -spd : spd;
        if (mag > lfpd_pkg::PWM_MAX)
            mag = lfpd_pkg::PWM_MAX;
        fwd = (spd > 0) ? lfpd_pkg::drive_t'(mag) : '0;
        rev = (spd < 0) ? lfpd_pkg::drive_t'(mag) : '0;
    endfunction

    function automatic lfpd_pkg::result_t predict_drive(
        input logic [lfpd_pkg::KIND_W-1:0]    kind,
        input logic [lfpd_pkg::IN_DATA_W-1:0] word
    );
        lfpd_pkg::sample_t s [lfpd_pkg::LINE_SENSORS];
        lfpd_pkg::sample_t mk;
        int                err;
        int                u;
        int                t;
        longint            acc;
        lfpd_pkg::result_t res;
        for (int i = 0; i < lfpd_pkg::LINE_SENSORS; i++)
            s[i] = word[i*lfpd_pkg::SAMPLE_BITS +: lfpd_pkg::SAMPLE_BITS];
        mk = word[lfpd_pkg::LINE_SENSORS*lfpd_pkg::SAMPLE_BITS +: lfpd_pkg::SAMPLE_BITS];

        case (kind)
            lfpd_pkg::KIND_CONTROL:
            begin
                if (!loop_on)
                begin
                    base = '0;
                    for (int i = 0; i < 4; i++)
                        drv[i] = '0;
                end
                else if (s[1] > thr[1])
                begin
                    if (base < tgt_speed)
                        base = base + ramp;
                    err = int'(s[2]) - int'(s[0]);
                    acc = longint'(kp) * err + longint'(kd) * (err - int'(prev_err));
                    // Arithmetic shift gives the floor toward minus infinity.
                    u = int'(acc >>> 8);
                    if (u > int'(clamp_hi))
                        u = int'(clamp_hi);
                    else if (u < -int'(clamp_lo))
                        u = -int'(clamp_lo);
                    prev_err = err[lfpd_pkg::ERR_W-1:0];
                    split_speed(int'(base) + u, drv[0], drv[1]);
                    split_speed(int'(base) - u, drv[2], drv[3]);
                end
            end
            lfpd_pkg::KIND_MONITOR:
            begin
                for (int i = 0; i < lfpd_pkg::LINE_SENSORS; i++)
                    mask[lfpd_pkg::LINE_SENSORS-1-i] = (s[i] > thr[i]);
                if (mask == '1)
                    loop_on = 1'b0;
                if (await_mk && !(mk > mark_lvl))
                begin
                    loop_on  = 1'b1;
                    await_mk = 1'b0;
                end
            end
            lfpd_pkg::KIND_CALIBRATE:
            begin
                for (int i = 0; i < lfpd_pkg::LINE_SENSORS; i++)
                begin
                    if (s[i] > hi_seen[i])
                        hi_seen[i] = s[i];
                    if (s[i] < lo_seen[i])
                        lo_seen[i] = s[i];
                    t = (int'(lo_seen[i]) + int'(hi_seen[i])) / 2 + int'(thr_ofs);
                    if (t < 0)
                        t = 0;
                    if (t > 4095)
                        t = 4095;
                    thr[i] = lfpd_pkg::sample_t'(t);
                end
            end
            lfpd_pkg::KIND_ARM_RUN:
            begin
                if (mask == 3'b010)
                    loop_on = 1'b1;
            end
            lfpd_pkg::KIND_ARM_MARKER:
                await_mk = 1'b1;
            default:
            begin
            end
        endcase

        res.left_forward  = drv[0];
        res.left_reverse  = drv[1];
        res.right_forward = drv[2];
        res.right_reverse = drv[3];
        res.line_mask     = mask;
        res.running       = loop_on;
        res.marker_seen   = await_mk && (mk > mark_lvl);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    task automatic compare_result(input logic [lfpd_pkg::OUT_DATA_W-1:0] word);
        lfpd_pkg::result_t got;
        lfpd_pkg::result_t want;
        got = lfpd_pkg::result_t'(word[$bits(lfpd_pkg::result_t)-1:0]);
        if (drive_results_due.size() == 0)
        begin
            $display("%0t: result with no item outstanding, expected none, actual %h",
                     $time, word);
            fail_count++;
        end
        else
        begin
            want = drive_results_due.pop_front();
            check_field("left_forward", 16'(want.left_forward), 16'(got.left_forward));
            check_field("left_reverse", 16'(want.left_reverse), 16'(got.left_reverse));
            check_field("right_forward", 16'(want.right_forward),
                        16'(got.right_forward));
            check_field("right_reverse", 16'(want.right_reverse),
                        16'(got.right_reverse));
            check_field("line_mask", 16'(want.line_mask), 16'(got.line_mask));
            check_field("running", 16'(want.running), 16'(got.running));
            check_field("marker_seen", 16'(want.marker_seen), 16'(got.marker_seen));
            check_field("padding", '0,
                        16'(word[lfpd_pkg::OUT_DATA_W-1:$bits(lfpd_pkg::result_t)]));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp        = 16'sd256;
            kd        = '0;
            tgt_speed = 10'd500;
            ramp      = 10'd10;
            clamp_hi  = 10'd500;
            clamp_lo  = 10'd500;
            mark_lvl  = 12'd2048;
            thr_ofs   = '0;
            prev_err  = '0;
            base      = '0;
            mask      = '0;
            loop_on   = 1'b0;
            await_mk  = 1'b0;
            for (int i = 0; i < 4; i++)
                drv[i] = '0;
            for (int i = 0; i < lfpd_pkg::LINE_SENSORS; i++)
            begin
                thr[i]     = '0;
                hi_seen[i] = '0;
                lo_seen[i] = '1;
            end
            drive_results_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lfpd_pkg::REG_PROP_GAIN:     kp        = cfg_data;
                    lfpd_pkg::REG_DERIV_GAIN:    kd        = cfg_data;
                    lfpd_pkg::REG_TARGET_SPEED:  tgt_speed = cfg_data[lfpd_pkg::SPEED_W-1:0];
                    lfpd_pkg::REG_RAMP_STEP:     ramp      = cfg_data[lfpd_pkg::SPEED_W-1:0];
                    lfpd_pkg::REG_LIMIT_UP:      clamp_hi  = cfg_data[lfpd_pkg::SPEED_W-1:0];
                    lfpd_pkg::REG_LIMIT_DOWN:    clamp_lo  = cfg_data[lfpd_pkg::SPEED_W-1:0];
                    lfpd_pkg::REG_MARKER_LEVEL:
                        mark_lvl = cfg_data[lfpd_pkg::SAMPLE_BITS-1:0];
                    lfpd_pkg::REG_THRESH_OFFSET:
                        thr_ofs  = cfg_data[lfpd_pkg::OFFSET_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            // Compare before queueing, so a result never matches the item of
            // the same edge.
            if (m_axis_tvalid && m_axis_tready)
                compare_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                drive_results_due.push_back(predict_drive(s_axis_tuser, s_axis_tdata));
            pending = drive_results_due.size();
        end
    end

endmodule

/* test/tb.sv */
// ============================================================================
// tb: regression bench of the line follower PD motor drive
// Drives directed and randomized sensor items through several register
// settings with random gaps and backpressure; the checker grades each result.
// ============================================================================
module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 170;
    localparam int PHASE_COUNT  = 8;
    localparam int STEADY_PHASE = 5;

    // Kind codes with no operation behind them.
    localparam logic [lfpd_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [lfpd_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [lfpd_pkg::KIND_W-1:0] KIND_SPARE_C = 3'd7;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lfpd_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [lfpd_pkg::KIND_W-1:0]     s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lfpd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [lfpd_pkg::CFG_DAT_W-1:0]  cfg_data      = '0;

    int   fails;
    int   pending;
    int   cycles     = 0;
    int   items_sent = 0;
    int   lvl_now    = 2048;
    logic steady     = 1'b0;

    line_follow_pd_motor_drive uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    motor_drive_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fails),
        .pending       (pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic lfpd_pkg::sample_t any_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return lfpd_pkg::sample_t'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic lfpd_pkg::sample_t line_hi();
        return lfpd_pkg::sample_t'($urandom_range(3600, 4095));
    endfunction

    function automatic lfpd_pkg::sample_t line_lo();
        return lfpd_pkg::sample_t'($urandom_range(0, 400));
    endfunction

    function automatic lfpd_pkg::sample_t marker_above();
        return (lvl_now >= 4095) ? lfpd_pkg::sample_t'(4095)
                                 : lfpd_pkg::sample_t'($urandom_range(lvl_now + 1, 4095));
    endfunction

    function automatic lfpd_pkg::sample_t marker_below();
        return lfpd_pkg::sample_t'($urandom_range(0, lvl_now));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [lfpd_pkg::KIND_W-1:0] kind,
                             input lfpd_pkg::sample_t left_s,
                             input lfpd_pkg::sample_t centre_s,
                             input lfpd_pkg::sample_t right_s,
                             input lfpd_pkg::sample_t marker_s);
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {marker_s, right_s, centre_s, left_s};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_cfg(input lfpd_pkg::reg_idx_t idx,
                             input logic [lfpd_pkg::CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic apply_setting(input int ph);
        int p_gain;
        int d_gain;
        int tgt;
        int step;
        int up;
        int down;
        int lvl;
        int ofs;
        case (ph)
            0:
            begin
                p_gain = 256;    d_gain = 0;     tgt = 500; step = 10;
                up = 500;        down = 500;     lvl = 2048; ofs = 0;
            end
            1:
            begin
                p_gain = 32767;  d_gain = -32768; tgt = 999; step = 999;
                up = 999;        down = 999;      lvl = 4095; ofs = 1024;
            end
            2:
            begin
                p_gain = -32768; d_gain = 32767; tgt = 0;   step = 0;
                up = 0;          down = 0;       lvl = 0;   ofs = -1024;
            end
            3:
            begin
                // Register values past the documented ranges, at full width.
                p_gain = $urandom_range(0, 65535);
                d_gain = $urandom_range(0, 65535);
                tgt = 1023; step = 1023; up = 1023; down = 1023;
                lvl = $urandom_range(0, 4095);
                ofs = $urandom_range(0, 1) ? 2047 : -2048;
            end
            default:
            begin
                p_gain = $urandom_range(0, 2047) - 1024;
                d_gain = $urandom_range(0, 65535);
                tgt    = $urandom_range(0, 999);
                step   = $urandom_range(1, 60);
                up     = $urandom_range(0, 999);
                down   = $urandom_range(0, 999);
                lvl    = $urandom_range(0, 4095);
                ofs    = $urandom_range(0, 2048) - 1024;
            end
        endcase
        write_cfg(lfpd_pkg::REG_PROP_GAIN, lfpd_pkg::CFG_DAT_W'(p_gain));
        write_cfg(lfpd_pkg::REG_DERIV_GAIN, lfpd_pkg::CFG_DAT_W'(d_gain));
        write_cfg(lfpd_pkg::REG_TARGET_SPEED, lfpd_pkg::CFG_DAT_W'(tgt));
        write_cfg(lfpd_pkg::REG_RAMP_STEP, lfpd_pkg::CFG_DAT_W'(step));
        write_cfg(lfpd_pkg::REG_LIMIT_UP, lfpd_pkg::CFG_DAT_W'(up));
        write_cfg(lfpd_pkg::REG_LIMIT_DOWN, lfpd_pkg::CFG_DAT_W'(down));
        write_cfg(lfpd_pkg::REG_MARKER_LEVEL, lfpd_pkg::CFG_DAT_W'(lvl));
        write_cfg(lfpd_pkg::REG_THRESH_OFFSET, lfpd_pkg::CFG_DAT_W'(ofs));
        cfg_valid <= 1'b0;
        lvl_now = lvl & 12'hFFF;
        @(negedge clk);
    endtask

    task automatic directed_items();
        send_item(lfpd_pkg::KIND_CONTROL, '1, '1, '1, '1);
        send_item(lfpd_pkg::KIND_MONITOR, '0, '0, '0, '0);
        send_item(lfpd_pkg::KIND_ARM_RUN, '0, '0, '0, '0);
        send_item(KIND_SPARE_A, any_sample(), any_sample(), any_sample(), any_sample());
        send_item(KIND_SPARE_B, any_sample(), any_sample(), any_sample(), any_sample());
        send_item(KIND_SPARE_C, any_sample(), any_sample(), any_sample(), any_sample());
        // Learn the full span so every threshold sits at mid scale.
        send_item(lfpd_pkg::KIND_CALIBRATE, '0, '0, '0, '0);
        send_item(lfpd_pkg::KIND_CALIBRATE, '1, '1, '1, '1);
        send_item(lfpd_pkg::KIND_MONITOR, '0, '1, '0, '0);
        send_item(lfpd_pkg::KIND_ARM_RUN, '0, '0, '0, '0);
        send_item(lfpd_pkg::KIND_CONTROL, '0, '1, '1, '0);
        send_item(lfpd_pkg::KIND_CONTROL, '1, '1, '0, '0);
        // Centre exactly at its threshold: the drive values hold.
        send_item(lfpd_pkg::KIND_CONTROL, 12'd100, 12'd2047, 12'd200, '0);
        send_item(lfpd_pkg::KIND_CONTROL, 12'd1500, 12'd3000, 12'd1500, '0);
        send_item(lfpd_pkg::KIND_ARM_MARKER, '0, '0, '0, '1);
        send_item(lfpd_pkg::KIND_MONITOR, '0, '1, '0, '1);
        // Marker exactly at its level counts as cleared.
        send_item(lfpd_pkg::KIND_MONITOR, '0, '1, '0, 12'd2048);
        send_item(lfpd_pkg::KIND_MONITOR, '1, '1, '1, '0);
        send_item(lfpd_pkg::KIND_CONTROL, 12'd2000, '1, 12'd2100, '0);
        send_item(lfpd_pkg::KIND_ARM_MARKER, '0, '0, '0, '0);
        // All three on the line stops the loop, then the pending start restarts it.
        send_item(lfpd_pkg::KIND_MONITOR, '1, '1, '1, '0);
        send_item(lfpd_pkg::KIND_CONTROL, 12'd2000, '1, 12'd2100, '0);
        send_item(lfpd_pkg::KIND_CALIBRATE, any_sample(), any_sample(), any_sample(),
                  any_sample());
    endtask

    task automatic control_item();
        lfpd_pkg::sample_t left_s;
        lfpd_pkg::sample_t right_s;
        lfpd_pkg::sample_t centre_s;
        int                mid;
        centre_s = ($urandom_range(0, 99) < 85) ? line_hi() : any_sample();
        if ($urandom_range(0, 1))
        begin
            left_s  = any_sample();
            right_s = any_sample();
        end
        else
        begin
            mid     = $urandom_range(1000, 3000);
            left_s  = lfpd_pkg::sample_t'(mid + $urandom_range(0, 200));
            right_s = lfpd_pkg::sample_t'(mid + $urandom_range(0, 200));
        end
        send_item(lfpd_pkg::KIND_CONTROL, left_s, centre_s, right_s, any_sample());
    endtask

    task automatic random_episode();
        if ($urandom_range(0, 99) < 75)
        begin
            repeat ($urandom_range(0, 2))
                send_item(lfpd_pkg::KIND_CALIBRATE, any_sample(), any_sample(),
                          any_sample(), any_sample());
            send_item(lfpd_pkg::KIND_MONITOR, line_lo(), line_hi(), line_lo(), any_sample());
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(lfpd_pkg::KIND_ARM_MARKER, any_sample(), any_sample(),
                          any_sample(), marker_above());
                repeat ($urandom_range(0, 2))
                    send_item(lfpd_pkg::KIND_MONITOR, line_lo(), line_hi(), line_lo(),
                              marker_above());
                send_item(lfpd_pkg::KIND_MONITOR, line_lo(), line_hi(), line_lo(),
                          marker_below());
            end
            else
                send_item(lfpd_pkg::KIND_ARM_RUN, any_sample(), any_sample(),
                          any_sample(), any_sample());
            repeat ($urandom_range(3, 20))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(lfpd_pkg::KIND_MONITOR,
                              $urandom_range(0, 1) ? line_hi() : line_lo(),
                              $urandom_range(0, 1) ? line_hi() : line_lo(),
                              $urandom_range(0, 1) ? line_hi() : line_lo(),
                              any_sample());
                else
                    control_item();
            end
            if ($urandom_range(0, 1))
                send_item(lfpd_pkg::KIND_MONITOR, line_hi(), line_hi(), line_hi(),
                          any_sample());
        end
        else
        begin
            repeat ($urandom_range(1, 5))
                send_item(lfpd_pkg::KIND_W'($urandom_range(0, 7)), any_sample(),
                          any_sample(), any_sample(), any_sample());
        end
    endtask

    initial
    begin
        int goal;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            apply_setting(ph);
            steady <= (ph == STEADY_PHASE);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                random_episode();
            // The sender holds off until every outstanding result is back.
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        steady <= 1'b0;
        repeat (8) @(negedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
